// ----- rtl/lppc_pkg.sv -----
// Package for the lidar packet parser: framing constants, packet layout
// offsets and the CRC-8 step function.
// No dependencies.
package lppc_pkg;

  localparam int unsigned POINTS_PER_PACKET = 12;
  localparam int unsigned PACKET_BYTES      = 47;
  localparam int unsigned POS_W             = 6;
  localparam int unsigned IDX_W             = 4;

  localparam logic [7:0] START_BYTE = 8'h54;
  localparam logic [7:0] INFO_BYTE  = 8'h2C;
  localparam logic [7:0] CRC_POLY   = 8'h4D;

  // byte positions within a packet
  localparam logic [POS_W-1:0] POS_SPEED_LO = 6'd2;
  localparam logic [POS_W-1:0] POS_SPEED_HI = 6'd3;
  localparam logic [POS_W-1:0] POS_START_LO = 6'd4;
  localparam logic [POS_W-1:0] POS_START_HI = 6'd5;
  localparam logic [POS_W-1:0] POS_POINTS   = 6'd6;
  localparam logic [POS_W-1:0] POS_END_LO   = 6'd42;
  localparam logic [POS_W-1:0] POS_END_HI   = 6'd43;
  localparam logic [POS_W-1:0] POS_STAMP_LO = 6'd44;
  localparam logic [POS_W-1:0] POS_STAMP_HI = 6'd45;
  localparam logic [POS_W-1:0] POS_CRC      = 6'd46;
  localparam logic [POS_W-1:0] POINT_STRIDE = 6'd3;

  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(POINTS_PER_PACKET - 1);

  // one byte of CRC-8, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

endpackage

// ----- rtl/lppc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module lppc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 47
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/lidar_packet_parser_crc8.sv -----
// Lidar packet parser top level. Uses lppc_pkg and lppc_ram.
// Frames 47-byte packets, checks the CRC-8 and emits twelve point results per good packet.

// A received byte is taken whenever offered while the parser is framing. The
// packet bytes go into a 47-entry RAM; the header fields are caught in
// registers as they pass. When the CRC byte matches, the parser stops taking
// bytes and plays out the twelve points: each point takes three byte reads on
// the RAM's single read port, whose read data is registered, and then keeps
// the result transaction on offer until it is taken. No byte is accepted
// until the burst is over. A packet with a bad CRC gives no result and costs
// nothing extra. No clearing pass is needed after reset.
module lidar_packet_parser_crc8 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  point_index_o,
  output logic [15:0] distance_mm_o,
  output logic [7:0]  intensity_o,
  output logic [15:0] rotation_speed_o,
  output logic [15:0] first_angle_o,
  output logic [15:0] final_angle_o,
  output logic [15:0] stamp_o,
  output logic        last_point_o
);

  localparam int unsigned PW = lppc_pkg::POS_W;

  typedef enum logic [1:0] {
    S_RX,
    S_FETCH,
    S_OUT
  } state_e;

  state_e                       state_q;
  logic [PW-1:0]                pos_q;
  logic [7:0]                   crc_q;
  logic [7:0]                   crc_d;
  logic [1:0]                   phase_q;
  logic [PW-1:0]                base_q;
  logic [lppc_pkg::IDX_W-1:0]   point_q;
  logic                         out_valid_q;
  logic [15:0]                  dist_q;
  logic [7:0]                   inten_q;
  logic [15:0]                  speed_q;
  logic [15:0]                  start_q;
  logic [15:0]                  end_q;
  logic [15:0]                  stamp_q;

  logic          in_fire;
  logic          ram_we;
  logic [PW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign in_ready_o = (state_q == S_RX);
  assign in_fire    = in_valid_i && in_ready_o;
  assign crc_d      = lppc_pkg::crc8_step(crc_q, rx_byte_i);

  assign ram_we = in_fire &&
                  (((pos_q == '0) && (rx_byte_i == lppc_pkg::START_BYTE)) ||
                   ((pos_q == PW'(1)) && (rx_byte_i == lppc_pkg::INFO_BYTE)) ||
                   ((pos_q >= lppc_pkg::POS_SPEED_LO) && (pos_q <= lppc_pkg::POS_CRC)));
  assign ram_raddr = base_q + PW'(phase_q);

  lppc_ram #(
    .WIDTH (8),
    .DEPTH (lppc_pkg::PACKET_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (rx_byte_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RX;
      pos_q       <= '0;
      crc_q       <= '0;
      phase_q     <= '0;
      base_q      <= '0;
      point_q     <= '0;
      out_valid_q <= 1'b0;
      dist_q      <= '0;
      inten_q     <= '0;
      speed_q     <= '0;
      start_q     <= '0;
      end_q       <= '0;
      stamp_q     <= '0;
    end else begin
      unique case (state_q)
        S_RX: begin
          if (in_valid_i) begin
            priority if (pos_q == '0) begin
              if (rx_byte_i == lppc_pkg::START_BYTE) begin
                crc_q <= lppc_pkg::crc8_step(8'h00, rx_byte_i);
                pos_q <= PW'(1);
              end
            end else if (pos_q == PW'(1)) begin
              // the info byte fixes the point count at twelve, so no length check
              if (rx_byte_i == lppc_pkg::INFO_BYTE) begin
                crc_q <= crc_d;
                pos_q <= PW'(2);
              end else begin
                pos_q <= '0;
              end
            end else if (pos_q < lppc_pkg::POS_CRC) begin
              crc_q <= crc_d;
              pos_q <= pos_q + PW'(1);
              unique case (pos_q)
                lppc_pkg::POS_SPEED_LO: speed_q[7:0]  <= rx_byte_i;
                lppc_pkg::POS_SPEED_HI: speed_q[15:8] <= rx_byte_i;
                lppc_pkg::POS_START_LO: start_q[7:0]  <= rx_byte_i;
                lppc_pkg::POS_START_HI: start_q[15:8] <= rx_byte_i;
                lppc_pkg::POS_END_LO:   end_q[7:0]    <= rx_byte_i;
                lppc_pkg::POS_END_HI:   end_q[15:8]   <= rx_byte_i;
                lppc_pkg::POS_STAMP_LO: stamp_q[7:0]  <= rx_byte_i;
                lppc_pkg::POS_STAMP_HI: stamp_q[15:8] <= rx_byte_i;
                default: ;
              endcase
            end else if (pos_q == lppc_pkg::POS_CRC) begin
              pos_q <= '0;
              // good CRC: start playing out the points, else drop the packet
              if (crc_q == rx_byte_i) begin
                state_q <= S_FETCH;
                point_q <= '0;
                base_q  <= lppc_pkg::POS_POINTS;
                phase_q <= '0;
              end
            end else begin
              pos_q <= '0;
            end
          end
        end
        S_FETCH: begin
          // read data arrives in the cycle after its address
          phase_q <= phase_q + 2'd1;
          unique case (phase_q)
            2'd0: ;
            2'd1: dist_q[7:0]  <= ram_rdata;
            2'd2: dist_q[15:8] <= ram_rdata;
            2'd3: begin
              inten_q     <= ram_rdata;
              out_valid_q <= 1'b1;
              state_q     <= S_OUT;
            end
            default: ;
          endcase
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (point_q == lppc_pkg::LAST_INDEX) begin
              state_q <= S_RX;
            end else begin
              point_q <= point_q + lppc_pkg::IDX_W'(1);
              base_q  <= base_q + lppc_pkg::POINT_STRIDE;
              phase_q <= '0;
              state_q <= S_FETCH;
            end
          end
        end
        default: state_q <= S_RX;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign point_index_o    = point_q;
  assign distance_mm_o    = dist_q;
  assign intensity_o      = inten_q;
  assign rotation_speed_o = speed_q;
  assign first_angle_o    = start_q;
  assign final_angle_o    = end_q;
  assign stamp_o          = stamp_q;
  assign last_point_o     = (point_q == lppc_pkg::LAST_INDEX);

endmodule

// ----- rtl/lppc_checker.sv -----
// Port-level checker for the lidar packet parser, bound to the top level.
// Uses lppc_pkg.
module lppc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [3:0]  point_index_o,
  input logic [15:0] distance_mm_o,
  input logic [7:0]  intensity_o,
  input logic        last_point_o
);

  // no byte is taken while a point transaction is on offer
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("byte accepted while a point is pending");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_point_o ==
      (point_index_o == lppc_pkg::IDX_W'(lppc_pkg::POINTS_PER_PACKET - 1))))
    else $error("last point flag disagrees with the point index");

  a_burst_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_point_o) |=>
      (!in_ready_o && (point_index_o == $past(point_index_o) + 4'd1)))
    else $error("point burst broken before the last point");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(distance_mm_o) && $stable(intensity_o)))
    else $error("stalled point transaction changed");

endmodule

bind lidar_packet_parser_crc8 lppc_checker u_lppc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .point_index_o (point_index_o),
  .distance_mm_o (distance_mm_o),
  .intensity_o   (intensity_o),
  .last_point_o  (last_point_o)
);
